### sv/assert_macros.svh
// assertion macros used by the rtl file stream_word_substitute.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sws assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define SWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sws assertion failed");

`endif

### sv/sws_pkg.sv
// types and constants for the stream word substitute block
package sws_pkg;

  localparam int unsigned HIST_LEN  = 7;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_R = 8'h72;
  localparam logic [7:0] CHAR_C = 8'h63;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_LO  = 3'd0,
    CFG_SEARCH_HI  = 3'd1,
    CFG_REPLACE_LO = 3'd2,
    CFG_REPLACE_HI = 3'd3,
    CFG_WORD_LEN   = 3'd4,
    CFG_EXCLUDE    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       was_replaced;
  } out_item_t;

endpackage

### sv/stream_word_substitute.sv
// stream word substitute: sliding window compare and fixed-length replace
// an accepted request is held, then enters the window or pushes the oldest window byte
// into the output register; one request per cycle sustained while the output does not
// stall. a request with last enters the window, then all window bytes are flushed; after
// lowering word_length, surplus window bytes are emitted first, both stalling the input
// rst_ni (async, active low) empties window and history, clears handshakes, resets config
`include "assert_macros.svh"

module stream_word_substitute
  import sws_pkg::*;
#(
  parameter int unsigned MAX_WORD = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int unsigned LEN_W = $clog2(MAX_WORD + 1);

  logic [63:0] srch_lo_q, srch_hi_q, repl_lo_q, repl_hi_q;
  logic [4:0]  wlen_q;
  logic        excl_q;

  logic [7:0]  win_q  [MAX_WORD];
  logic [7:0]  win_d  [MAX_WORD];
  logic        mark_q [MAX_WORD];
  logic        mark_d [MAX_WORD];
  logic [LEN_W-1:0] fill_q, fill_d;
  logic [7:0]  hist_q [HIST_LEN];
  logic [7:0]  hist_d [HIST_LEN];
  logic [2:0]  hfill_q, hfill_d;
  logic        flush_q, flush_d;

  logic        hold_q, hold_d;
  in_item_t    hold_data_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;

  logic [7:0]  srch_b [MAX_WORD];
  logic [7:0]  repl_b [MAX_WORD];
  logic [7:0]  pw     [MAX_WORD];
  logic        pm     [MAX_WORD];
  logic [7:0]  nw     [MAX_WORD];
  logic        nm     [MAX_WORD];
  logic [7:0]  src_b  [MAX_WORD];
  logic        src_m  [MAX_WORD];

  logic [LEN_W-1:0] len;
  logic        slot_free, accept, done;
  logic        hit, excl_hit, full_after, do_match;
  logic        emit, emit_last;

  // word bytes, zero from byte sixteen up
  for (genvar g = 0; g < MAX_WORD; g++) begin : g_word
    if (g < 8) begin : g_lo
      assign srch_b[g] = srch_lo_q[8*g +: 8];
      assign repl_b[g] = repl_lo_q[8*g +: 8];
    end else if (g < 16) begin : g_hi
      assign srch_b[g] = srch_hi_q[8*(g-8) +: 8];
      assign repl_b[g] = repl_hi_q[8*(g-8) +: 8];
    end else begin : g_zero
      assign srch_b[g] = 8'h00;
      assign repl_b[g] = 8'h00;
    end
  end

  always_comb begin
    if (wlen_q == 5'd0) begin
      len = LEN_W'(1);
    end else if (int'(wlen_q) > MAX_WORD) begin
      len = LEN_W'(MAX_WORD);
    end else begin
      len = LEN_W'(wlen_q);
    end
  end

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = hold_q && !done;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // window with the held byte pushed, then the match test on it and the replaced window
  always_comb begin
    for (int i = 0; i < MAX_WORD; i++) begin
      if (LEN_W'(i) == fill_q) begin
        pw[i] = hold_data_q.data_byte;
        pm[i] = 1'b0;
      end else begin
        pw[i] = win_q[i];
        pm[i] = mark_q[i];
      end
    end
    hit = 1'b1;
    for (int i = 0; i < MAX_WORD; i++) begin
      if (LEN_W'(i) < len && (pm[i] || pw[i] != srch_b[i])) begin
        hit = 1'b0;
      end
    end
    excl_hit = excl_q && hfill_q == 3'(HIST_LEN) && hist_q[6] == CHAR_S &&
               hist_q[5] == CHAR_R && hist_q[4] == CHAR_C;
    full_after = (LEN_W'(fill_q + 1'b1) == len);
    do_match   = full_after && hit && !excl_hit;
    for (int i = 0; i < MAX_WORD; i++) begin
      if (do_match && LEN_W'(i) < len) begin
        nw[i] = repl_b[i];
        nm[i] = 1'b1;
      end else begin
        nw[i] = pw[i];
        nm[i] = pm[i];
      end
    end
  end

  always_comb begin
    win_d     = win_q;
    mark_d    = mark_q;
    fill_d    = fill_q;
    hist_d    = hist_q;
    hfill_d   = hfill_q;
    flush_d   = flush_q;
    src_b     = win_q;
    src_m     = mark_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    done      = 1'b0;

    if (hold_q && slot_free) begin
      if (flush_q) begin
        emit      = 1'b1;
        emit_last = (fill_q == LEN_W'(1));
        fill_d    = fill_q - 1'b1;
      end else if (fill_q >= len) begin
        emit   = 1'b1;
        fill_d = fill_q - 1'b1;
      end else if (hold_data_q.is_last) begin
        win_d   = nw;
        mark_d  = nm;
        fill_d  = fill_q + 1'b1;
        flush_d = 1'b1;
      end else if (full_after) begin
        emit  = 1'b1;
        src_b = nw;
        src_m = nm;
        done  = 1'b1;
      end else begin
        win_d  = nw;
        mark_d = nm;
        fill_d = fill_q + 1'b1;
        done   = 1'b1;
      end
    end

    if (emit) begin
      for (int i = 0; i < MAX_WORD - 1; i++) begin
        win_d[i]  = src_b[i+1];
        mark_d[i] = src_m[i+1];
      end
      win_d[MAX_WORD-1]  = src_b[MAX_WORD-1];
      mark_d[MAX_WORD-1] = src_m[MAX_WORD-1];
      for (int i = HIST_LEN - 1; i > 0; i--) begin
        hist_d[i] = hist_q[i-1];
      end
      hist_d[0] = src_b[0];
      if (hfill_q != 3'(HIST_LEN)) begin
        hfill_d = hfill_q + 1'b1;
      end
    end

    // packet end: window and history start empty
    if (emit && emit_last) begin
      done    = 1'b1;
      flush_d = 1'b0;
      hfill_d = '0;
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_d[i] = 8'h00;
      end
      for (int i = 0; i < MAX_WORD; i++) begin
        mark_d[i] = 1'b0;
      end
    end
  end

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = 1'b1;
    end else if (done) begin
      hold_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d             = 1'b1;
      out_data_d.out_byte     = src_b[0];
      out_data_d.out_last     = emit_last;
      out_data_d.was_replaced = src_m[0];
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_lo_q   <= '0;
      srch_hi_q   <= '0;
      repl_lo_q   <= '0;
      repl_hi_q   <= '0;
      wlen_q      <= 5'd1;
      excl_q      <= 1'b1;
      fill_q      <= '0;
      hfill_q     <= '0;
      flush_q     <= 1'b0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_WORD; i++) begin
        mark_q[i] <= 1'b0;
      end
    end else begin
      fill_q      <= fill_d;
      hfill_q     <= hfill_d;
      flush_q     <= flush_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
      mark_q      <= mark_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SEARCH_LO:  srch_lo_q <= cfg_data_i;
          CFG_SEARCH_HI:  srch_hi_q <= cfg_data_i;
          CFG_REPLACE_LO: repl_lo_q <= cfg_data_i;
          CFG_REPLACE_HI: repl_hi_q <= cfg_data_i;
          CFG_WORD_LEN:   wlen_q    <= cfg_data_i[4:0];
          CFG_EXCLUDE:    excl_q    <= cfg_data_i[0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    hist_q     <= hist_d;
    out_data_q <= out_data_d;
    if (accept) begin
      hold_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SWS_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= LEN_W'(MAX_WORD))
  `SWS_ASSERT_IMP(a_flush_held, flush_q, hold_q)
  `SWS_ASSERT_NXT(a_flush_clears, emit && emit_last, fill_q == '0 && hfill_q == '0 && !flush_q)

endmodule
